@@ hw/rtl/hmt_pkg.sv @@
// Shared types, codes and constants of the heartbeat membership table.
package hmt_pkg;

  localparam int TABLE_DEPTH = 32;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_JOIN_REQ = 2'd1,
    CMD_JOIN_REP = 2'd2,
    CMD_HEARTBT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SEND_HB = 3'd1,
    KIND_JOIN_RE = 3'd2,
    KIND_REMOVED = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_ID       = 2'd0,
    REG_OWN_PORT     = 2'd1,
    REG_PING_PERIOD  = 2'd2,
    REG_REMOVE_AFTER = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_INS,
    ST_HBUPD,
    ST_JRWALK,
    ST_PING,
    ST_STALE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        sender_id;
    logic signed [15:0] sender_port;
    logic [31:0]        sender_heartbeat;
    logic signed [31:0] entry_stamp;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        dest_id;
    logic signed [15:0] dest_port;
    logic [15:0]        member_id;
    logic signed [15:0] member_port;
    logic [31:0]        beat_value;
    logic signed [31:0] stamp_value;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    state_t phase;
    logic   first;
    logic   accept;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic stale;
    logic active;
    logic cd_zero;
  } sts_t;

endpackage

@@ hw/rtl/heartbeat_membership_table_core.sv @@
// Top level of the heartbeat membership table: controller plus datapath.
// Requests are taken when start is high and busy low; every request yields one or more
// results, each on out_res for a single cycle with out_valid, the final one carrying
// last; results cannot be held off. The table memory has a registered read; each table walk
// (lookup, join reply, heartbeat round, stale scan, removal shift) reads the entries in turn.
// A tick goes straight to done while the node is neither joined nor at own id 1, port 0.
// Other requests look the sender up: a heartbeat from a known sender updates its entry, a new
// sender is inserted, and a join request then walks the table for join replies. An active
// tick runs a heartbeat round when its countdown is zero, then a stale scan and, for a stale
// entry, a removal shift. The next request is taken in the idle state that follows done.
// There is no clearing pass.
module heartbeat_membership_table_core #(
  parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hmt_pkg::in_t  in_req,
  output logic          out_valid,
  output hmt_pkg::out_t out_res,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata
);

  hmt_pkg::ctl_t ctl;
  hmt_pkg::sts_t sts;

  hmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_req.command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  hmt_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |-> !busy) else $error("last result while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted without going busy");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind == hmt_pkg::KIND_NONE |-> out_res.last)
    else $error("empty result not final");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && out_valid |-> out_res.last) else $error("non-final result while idle");
`endif

endmodule

@@ hw/rtl/hmt_ctrl.sv @@
// Controller state machine sequencing the table operations of one request.
module hmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_command,
  input  hmt_pkg::sts_t   sts,
  output hmt_pkg::ctl_t   ctl,
  output logic            busy
);

  hmt_pkg::state_t state_r, state_nxt;
  logic            first_r;
  logic [1:0]      cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmt_pkg::ST_IDLE;
      first_r <= 1'b0;
      cmd_r   <= hmt_pkg::CMD_TICK;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);
      if (start && state_r == hmt_pkg::ST_IDLE) begin
        cmd_r <= in_command;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hmt_pkg::ST_IDLE: begin
        if (start) begin
          if (in_command == hmt_pkg::CMD_TICK) begin
            if (!sts.active) state_nxt = hmt_pkg::ST_DONE;
            else if (sts.cd_zero) state_nxt = hmt_pkg::ST_PING;
            else state_nxt = hmt_pkg::ST_STALE;
          end else begin
            state_nxt = hmt_pkg::ST_FIND;
          end
        end
      end
      hmt_pkg::ST_FIND: begin
        if (sts.hit && cmd_r == hmt_pkg::CMD_HEARTBT) state_nxt = hmt_pkg::ST_HBUPD;
        else if (sts.hit || sts.done) state_nxt = hmt_pkg::ST_INS;
      end
      hmt_pkg::ST_INS: begin
        state_nxt = (cmd_r == hmt_pkg::CMD_JOIN_REQ) ? hmt_pkg::ST_JRWALK : hmt_pkg::ST_DONE;
      end
      hmt_pkg::ST_HBUPD:  state_nxt = hmt_pkg::ST_DONE;
      hmt_pkg::ST_JRWALK: if (sts.done) state_nxt = hmt_pkg::ST_DONE;
      hmt_pkg::ST_PING:   if (sts.done) state_nxt = hmt_pkg::ST_STALE;
      hmt_pkg::ST_STALE: begin
        if (sts.stale) state_nxt = hmt_pkg::ST_SHIFT;
        else if (sts.done) state_nxt = hmt_pkg::ST_DONE;
      end
      hmt_pkg::ST_SHIFT:  if (sts.done) state_nxt = hmt_pkg::ST_DONE;
      hmt_pkg::ST_DONE:   state_nxt = hmt_pkg::ST_IDLE;
      default:            state_nxt = hmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.phase  = state_r;
    ctl.first  = first_r;
    ctl.accept = start && (state_r == hmt_pkg::ST_IDLE);
    busy       = (state_r != hmt_pkg::ST_IDLE);
  end

endmodule

@@ hw/rtl/hmt_dpath.sv @@
// Datapath: table memory, table walker, node state and result staging.
module hmt_dpath #(
  parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hmt_pkg::ctl_t ctl,
  input  hmt_pkg::in_t  in_req,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata,
  output hmt_pkg::sts_t sts,
  output logic          out_valid,
  output hmt_pkg::out_t out_res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  hmt_pkg::entry_t mem [TABLE_DEPTH];
  hmt_pkg::entry_t mem_q_r;

  logic [15:0] own_id_r, own_port_r, remove_after_r;
  logic [7:0]  ping_period_r, cd_r;
  logic [31:0] beat_r, time_r;
  logic        joined_r;
  logic [CW-1:0] count_r, ptr_r, idx1_r, hit_idx_r, stale_idx_r;
  logic        v1_r, hit_r, stale_r;
  logic [15:0] hit_port_r;
  hmt_pkg::in_t item_r;

  logic          walk;
  logic          ev;
  logic [CW-1:0] ptr_init;
  logic          done;
  logic          is_self, is_stale, id_match;
  logic signed [32:0] age;
  logic          we;
  logic [AW-1:0] wa, ra;
  hmt_pkg::entry_t wd;
  logic          new_v;
  hmt_pkg::out_t new_res, pend_r;
  hmt_pkg::out_t done_res;
  logic          pend_v_r;
  logic          tick_active;
  logic [31:0]   ins_stamp;

  assign walk = (ctl.phase == hmt_pkg::ST_FIND) || (ctl.phase == hmt_pkg::ST_JRWALK)
             || (ctl.phase == hmt_pkg::ST_PING) || (ctl.phase == hmt_pkg::ST_STALE)
             || (ctl.phase == hmt_pkg::ST_SHIFT);
  assign ev       = walk && !ctl.first && v1_r;
  assign ptr_init = (ctl.phase == hmt_pkg::ST_SHIFT) ? stale_idx_r + CW'(1) : '0;
  assign done     = walk && !ctl.first && (ptr_r >= count_r) && !v1_r;
  assign ra       = ptr_r[AW-1:0];
  assign id_match = (mem_q_r.id == item_r.sender_id);
  assign is_self  = (mem_q_r.id == own_id_r) && (mem_q_r.port == own_port_r);
  assign age      = $signed({time_r[31], time_r}) - $signed({mem_q_r.stamp[31], mem_q_r.stamp});
  assign is_stale = age > $signed({17'b0, remove_after_r});
  assign tick_active = joined_r || (own_id_r == 16'd1 && own_port_r == 16'd0);
  assign ins_stamp = (item_r.command == hmt_pkg::CMD_JOIN_REP) ? item_r.entry_stamp : time_r;

  always_comb begin
    sts.done    = done;
    sts.hit     = hit_r;
    sts.stale   = stale_r;
    sts.active  = tick_active;
    sts.cd_zero = (cd_r == 8'd0);
  end

  always_comb begin
    done_res      = pend_v_r ? pend_r : '0;
    done_res.last = 1'b1;
  end

  always_comb begin
    we      = 1'b0;
    wa      = count_r[AW-1:0];
    wd      = '{id: item_r.sender_id, port: item_r.sender_port,
                beat: item_r.sender_heartbeat, stamp: ins_stamp};
    new_v   = 1'b0;
    new_res = '0;
    unique case (ctl.phase)
      hmt_pkg::ST_INS: begin
        if (!hit_r) begin
          if (count_r >= FULL) begin
            new_v               = 1'b1;
            new_res.kind        = hmt_pkg::KIND_FULL;
            new_res.member_id   = item_r.sender_id;
            new_res.member_port = item_r.sender_port;
            new_res.beat_value  = item_r.sender_heartbeat;
            new_res.stamp_value = ins_stamp;
          end else begin
            we = 1'b1;
          end
        end
      end
      hmt_pkg::ST_HBUPD: begin
        we      = 1'b1;
        wa      = hit_idx_r[AW-1:0];
        wd.port = hit_port_r;
        wd.stamp = time_r;
      end
      hmt_pkg::ST_JRWALK: begin
        if (ev) begin
          new_v               = 1'b1;
          new_res.kind        = hmt_pkg::KIND_JOIN_RE;
          new_res.dest_id     = item_r.sender_id;
          new_res.dest_port   = item_r.sender_port;
          new_res.member_id   = mem_q_r.id;
          new_res.member_port = mem_q_r.port;
          new_res.beat_value  = mem_q_r.beat;
          new_res.stamp_value = mem_q_r.stamp;
        end
      end
      hmt_pkg::ST_PING: begin
        if (ev && !is_self) begin
          new_v              = 1'b1;
          new_res.kind       = hmt_pkg::KIND_SEND_HB;
          new_res.dest_id    = mem_q_r.id;
          new_res.dest_port  = mem_q_r.port;
          new_res.beat_value = beat_r;
        end
      end
      hmt_pkg::ST_STALE: begin
        if (ev && !stale_r && !is_self && is_stale) begin
          new_v               = 1'b1;
          new_res.kind        = hmt_pkg::KIND_REMOVED;
          new_res.member_id   = mem_q_r.id;
          new_res.member_port = mem_q_r.port;
          new_res.beat_value  = mem_q_r.beat;
          new_res.stamp_value = mem_q_r.stamp;
        end
      end
      hmt_pkg::ST_SHIFT: begin
        if (ev) begin
          we = 1'b1;
          wa = AW'(idx1_r - CW'(1));
          wd = mem_q_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_r <= in_req;
    end
    if (ev && ctl.phase == hmt_pkg::ST_FIND && !hit_r && id_match) begin
      hit_idx_r  <= idx1_r;
      hit_port_r <= mem_q_r.port;
    end
    if (new_v && ctl.phase == hmt_pkg::ST_STALE) begin
      stale_idx_r <= idx1_r;
    end
    if (new_v) begin
      pend_r <= new_res;
    end
    idx1_r <= ptr_r;
    if (new_v && pend_v_r) begin
      out_res <= pend_r;
    end else if (ctl.phase == hmt_pkg::ST_DONE) begin
      out_res <= done_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r       <= 16'd1;
      own_port_r     <= 16'd0;
      ping_period_r  <= 8'd5;
      remove_after_r <= 16'd20;
      cd_r           <= 8'd5;
      beat_r         <= '0;
      time_r         <= '1;
      joined_r       <= 1'b0;
      count_r        <= '0;
      ptr_r          <= '0;
      v1_r           <= 1'b0;
      hit_r          <= 1'b0;
      stale_r        <= 1'b0;
      pend_v_r       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (hmt_pkg::reg_idx_t'(cfg_idx))
          hmt_pkg::REG_OWN_ID:       own_id_r       <= cfg_wdata;
          hmt_pkg::REG_OWN_PORT:     own_port_r     <= cfg_wdata;
          hmt_pkg::REG_PING_PERIOD:  ping_period_r  <= cfg_wdata[7:0];
          hmt_pkg::REG_REMOVE_AFTER: remove_after_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (ctl.accept) begin
        hit_r   <= 1'b0;
        stale_r <= 1'b0;
        if (in_req.command == hmt_pkg::CMD_JOIN_REP) begin
          joined_r <= 1'b1;
        end
        if (in_req.command == hmt_pkg::CMD_TICK && tick_active) begin
          if (cd_r == 8'd0) begin
            cd_r <= ping_period_r;
            if (beat_r != '1) beat_r <= beat_r + 32'd1;
          end else begin
            cd_r <= cd_r - 8'd1;
          end
        end
      end
      if (walk) begin
        if (ctl.first) begin
          ptr_r <= ptr_init;
          v1_r  <= 1'b0;
        end else begin
          v1_r <= (ptr_r < count_r);
          if (ptr_r < count_r) ptr_r <= ptr_r + CW'(1);
        end
      end
      if (ev && ctl.phase == hmt_pkg::ST_FIND && id_match) begin
        hit_r <= 1'b1;
      end
      if (new_v && ctl.phase == hmt_pkg::ST_STALE) begin
        stale_r <= 1'b1;
      end
      if (we && ctl.phase == hmt_pkg::ST_INS) begin
        count_r <= count_r + CW'(1);
      end
      if (ctl.phase == hmt_pkg::ST_DONE && item_r.command == hmt_pkg::CMD_TICK
          && tick_active) begin
        if (stale_r) count_r <= count_r - CW'(1);
        if (time_r != 32'h7FFF_FFFF) time_r <= time_r + 32'd1;
      end
      if (new_v) begin
        pend_v_r  <= 1'b1;
        out_valid <= pend_v_r;
      end else if (ctl.phase == hmt_pkg::ST_DONE) begin
        pend_v_r  <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb_heartbeat_membership_table_core.sv @@
// Testbench of the heartbeat membership table: random and directed requests against a model.
`timescale 1ns / 100ps

module tb_heartbeat_membership_table_core;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  hmt_pkg::in_t  in_req = '0;
  logic          out_valid;
  hmt_pkg::out_t out_res;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_idx = '0;
  logic [15:0]   cfg_wdata = '0;

  heartbeat_membership_table_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Membership model
  logic [15:0] mem_id [hmt_pkg::TABLE_DEPTH];
  logic [15:0] mem_port [hmt_pkg::TABLE_DEPTH];
  logic [31:0] mem_beat [hmt_pkg::TABLE_DEPTH];
  logic [31:0] mem_stamp [hmt_pkg::TABLE_DEPTH];
  int          mem_count;
  logic [31:0] beat_now;
  logic [7:0]  countdown;
  logic [31:0] clock_now;
  logic        in_group;
  logic [15:0] node_id, node_port, remove_limit;
  logic [7:0]  period;

  hmt_pkg::out_t expected_results[$];
  int   fail_count = 0;
  bit   burst_mode = 0;
  int   items_sent = 0;

  function automatic void push_result(hmt_pkg::kind_t k, logic [15:0] did,
                                      logic [15:0] dport, logic [15:0] mid,
                                      logic [15:0] mport, logic [31:0] bv,
                                      logic [31:0] sv);
    hmt_pkg::out_t r;
    r = '{k, did, dport, mid, mport, bv, sv, 1'b0};
    expected_results.push_back(r);
  endfunction

  function automatic int find_member(logic [15:0] id);
    for (int i = 0; i < mem_count; i++)
      if (mem_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit add_member(logic [15:0] id, logic [15:0] port, logic [31:0] bv,
                                    logic [31:0] sv);
    if (find_member(id) >= 0) return 1;
    if (mem_count >= hmt_pkg::TABLE_DEPTH) return 0;
    mem_id[mem_count] = id;
    mem_port[mem_count] = port;
    mem_beat[mem_count] = bv;
    mem_stamp[mem_count] = sv;
    mem_count++;
    return 1;
  endfunction

  function automatic bit is_own(int i);
    return mem_id[i] == node_id && mem_port[i] == node_port;
  endfunction

  function automatic void model_reset();
    node_id = 16'd1;
    node_port = 16'd0;
    period = 8'd5;
    remove_limit = 16'd20;
    mem_count = 0;
    beat_now = '0;
    countdown = 8'd5;
    clock_now = '1;
    in_group = 1'b0;
  endfunction

  function automatic void model_write(hmt_pkg::reg_idx_t idx, logic [15:0] v);
    case (idx)
      hmt_pkg::REG_OWN_ID:       node_id = v;
      hmt_pkg::REG_OWN_PORT:     node_port = v;
      hmt_pkg::REG_PING_PERIOD:  period = v[7:0];
      hmt_pkg::REG_REMOVE_AFTER: remove_limit = v;
    endcase
  endfunction

  function automatic void predict_membership(hmt_pkg::in_t r);
    int before_n;
    int f;
    longint age;
    before_n = expected_results.size();
    case (hmt_pkg::cmd_t'(r.command))
      hmt_pkg::CMD_JOIN_REQ: begin
        if (!add_member(r.sender_id, r.sender_port, r.sender_heartbeat, clock_now))
          push_result(hmt_pkg::KIND_FULL, '0, '0, r.sender_id, r.sender_port,
                      r.sender_heartbeat, clock_now);
        for (int i = 0; i < mem_count; i++)
          push_result(hmt_pkg::KIND_JOIN_RE, r.sender_id, r.sender_port, mem_id[i],
                      mem_port[i], mem_beat[i], mem_stamp[i]);
      end
      hmt_pkg::CMD_JOIN_REP: begin
        in_group = 1'b1;
        if (!add_member(r.sender_id, r.sender_port, r.sender_heartbeat, r.entry_stamp))
          push_result(hmt_pkg::KIND_FULL, '0, '0, r.sender_id, r.sender_port,
                      r.sender_heartbeat, r.entry_stamp);
      end
      hmt_pkg::CMD_HEARTBT: begin
        f = find_member(r.sender_id);
        if (f >= 0) begin
          mem_beat[f] = r.sender_heartbeat;
          mem_stamp[f] = clock_now;
        end else if (!add_member(r.sender_id, r.sender_port, r.sender_heartbeat,
                                 clock_now)) begin
          push_result(hmt_pkg::KIND_FULL, '0, '0, r.sender_id, r.sender_port,
                      r.sender_heartbeat, clock_now);
        end
      end
      default: begin
        if (in_group || (node_id == 16'd1 && node_port == 16'd0)) begin
          if (countdown == 0) begin
            if (beat_now != '1) beat_now++;
            for (int i = 0; i < mem_count; i++)
              if (!is_own(i))
                push_result(hmt_pkg::KIND_SEND_HB, mem_id[i], mem_port[i], '0, '0,
                            beat_now, '0);
            countdown = period;
          end else begin
            countdown--;
          end
          for (int i = 0; i < mem_count; i++) begin
            if (is_own(i)) continue;
            age = longint'($signed(clock_now)) - longint'($signed(mem_stamp[i]));
            if (age > longint'(remove_limit)) begin
              push_result(hmt_pkg::KIND_REMOVED, '0, '0, mem_id[i], mem_port[i],
                          mem_beat[i], mem_stamp[i]);
              for (int j = i; j + 1 < mem_count; j++) begin
                mem_id[j] = mem_id[j + 1];
                mem_port[j] = mem_port[j + 1];
                mem_beat[j] = mem_beat[j + 1];
                mem_stamp[j] = mem_stamp[j + 1];
              end
              mem_count--;
              break;
            end
          end
          if (clock_now != 32'h7fff_ffff) clock_now++;
        end
      end
    endcase
    if (expected_results.size() == before_n)
      push_result(hmt_pkg::KIND_NONE, '0, '0, '0, '0, '0, '0);
    expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    hmt_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_res);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_res.kind));
        check_field("dest_id", 32'(e.dest_id), 32'(out_res.dest_id));
        check_field("dest_port", 32'(e.dest_port), 32'(out_res.dest_port));
        check_field("member_id", 32'(e.member_id), 32'(out_res.member_id));
        check_field("member_port", 32'(e.member_port), 32'(out_res.member_port));
        check_field("beat_value", e.beat_value, out_res.beat_value);
        check_field("stamp_value", e.stamp_value, out_res.stamp_value);
        check_field("last", 32'(e.last), 32'(out_res.last));
      end
    end
  end

  task automatic send_request(hmt_pkg::cmd_t c, logic [15:0] id, logic [15:0] port,
                              logic [31:0] bv, logic [31:0] sv);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= '{c, id, port, bv, sv};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_membership(in_req);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] id, logic [15:0] port, logic [7:0] per,
                           logic [15:0] rem);
    logic [15:0] vals [4];
    vals = '{id, port, {8'd0, per}, rem};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= hmt_pkg::reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      model_write(hmt_pkg::reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_introducer_basics();
    burst_mode = 0;
    send_request(hmt_pkg::CMD_TICK, '0, '0, '0, '0);
    send_request(hmt_pkg::CMD_JOIN_REQ, 16'd5, 16'sd7, 32'd3, '0);
    send_request(hmt_pkg::CMD_HEARTBT, 16'hffff, 16'h8000, 32'hffff_ffff, '0);
    send_request(hmt_pkg::CMD_HEARTBT, 16'd5, 16'h7fff, 32'd9, '0);
    send_request(hmt_pkg::CMD_HEARTBT, 16'd1, 16'd0, 32'd0, '0);
    send_request(hmt_pkg::CMD_JOIN_REP, 16'd0, 16'd1, 32'h8000_0000, 32'hffff_ffff);
    send_request(hmt_pkg::CMD_JOIN_REP, 16'd9, 16'd2, 32'd1, 32'h7fff_ffff);
    repeat (6) send_request(hmt_pkg::CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_full_table();
    burst_mode = 1;
    for (int i = 0; i < 34; i++)
      send_request(hmt_pkg::CMD_HEARTBT, 16'(100 + i), 16'(i), $urandom, '0);
    send_request(hmt_pkg::CMD_JOIN_REQ, 16'd900, 16'sd3, 32'd4, '0);
    send_request(hmt_pkg::CMD_JOIN_REP, 16'd901, 16'sd4, 32'd5, 32'd6);
  endtask

  task automatic test_stale_removal();
    configure(16'd1, 16'd0, 8'd0, 16'd0);
    burst_mode = 0;
    repeat (8) send_request(hmt_pkg::CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_not_joined();
    configure(16'd7, 16'sd3, 8'd255, 16'd65535);
    send_request(hmt_pkg::CMD_TICK, '0, '0, '0, '0);
    send_request(hmt_pkg::CMD_HEARTBT, 16'd7, 16'sd3, 32'd2, '0);
    send_request(hmt_pkg::CMD_JOIN_REP, 16'd1, 16'd0, 32'd0, 32'd0);
    send_request(hmt_pkg::CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic random_phase(int n);
    int sel;
    logic [15:0] id, port;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      id = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      sel = $urandom_range(0, 3);
      port = (sel == 0) ? 16'($urandom) : (sel == 1) ? node_port : 16'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) id = node_id;
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_request(hmt_pkg::CMD_TICK, 16'($urandom), 16'($urandom), $urandom, $urandom);
      else if (sel < 70)
        send_request(hmt_pkg::CMD_HEARTBT, id, port, $urandom, $urandom);
      else if (sel < 85)
        send_request(hmt_pkg::CMD_JOIN_REQ, id, port, $urandom, $urandom);
      else
        send_request(hmt_pkg::CMD_JOIN_REP, id, port, $urandom,
                     ($urandom_range(0, 1) == 0) ? $urandom : clock_now - $urandom_range(0, 30));
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_introducer_basics();
    test_full_table();
    test_stale_removal();
    test_not_joined();
    configure(16'd1, 16'd0, 8'd3, 16'd6);
    random_phase(30);
    configure(16'($urandom), 16'($urandom), 8'd0, 16'd0);
    random_phase(25);
    configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 2)), 8'd255, 16'd65535);
    random_phase(25);
    configure(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom_range(0, 40)));
    random_phase(30);
    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
